/* hdl/gnto_pkg.sv */
// Package for the greedy nearest target order block: constants, codes and the sequencer state type.
`default_nettype none
package gnto_pkg;

   localparam int MAX_STAINS = 32;

   localparam int COORD_W = 16;
   localparam int SCORE_W = 16;
   localparam int DIST_W = 17;
   localparam int ENTRY_W = 2 * COORD_W + SCORE_W;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_START_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y = 2'd1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_PLAN = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

/* hdl/gnto_ram.sv */
// Generic single write port, single read port RAM with a registered read.
`default_nettype none
module gnto_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

/* hdl/greedy_nearest_target_order_top.sv */
// Top level of the greedy nearest target order block: point store, scan sequencer and results.
//
//  channel   ports                        handshake
//  request   req_cmd, req_point_*         start high while busy low
//  result    rsp_out_*, rsp_step_distance,
//            rsp_is_last/empty/overflowed rsp_valid strobe, one cycle each
//  config    csr_index, csr_wdata          csr_we high, no wait
//
// A load transaction does not leave the idle state, so loads may follow back to back.
// A plan over n stored points makes n picks: each pick issues every
// entry through the one RAM read port and the shared distance and compare
// unit, compares the last read in the cycle after its issue, then sees that
// the scan has drained, then emits its result.
// An empty plan gives its single result in the cycle after acceptance.
// Synchronous reset clears the point count, visited flags and overflow flag;
// no clearing pass is needed. Results cannot be stalled by the receiver.
`default_nettype none
module greedy_nearest_target_order_top #(
   parameter int MAX_STAINS = gnto_pkg::MAX_STAINS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_cmd,
   input  wire logic signed [gnto_pkg::COORD_W-1:0] req_point_x,
   input  wire logic signed [gnto_pkg::COORD_W-1:0] req_point_y,
   input  wire logic        [gnto_pkg::SCORE_W-1:0] req_point_score,
   output logic                                     rsp_valid,
   output logic signed      [gnto_pkg::COORD_W-1:0] rsp_out_x,
   output logic signed      [gnto_pkg::COORD_W-1:0] rsp_out_y,
   output logic             [gnto_pkg::SCORE_W-1:0] rsp_out_score,
   output logic             [gnto_pkg::DIST_W-1:0]  rsp_step_distance,
   output logic                                     rsp_is_last,
   output logic                                     rsp_is_empty,
   output logic                                     rsp_overflowed,
   input  wire logic                                csr_we,
   input  wire logic [gnto_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [gnto_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW = (MAX_STAINS > 1) ? $clog2(MAX_STAINS) : 1;
   localparam int CW = $clog2(MAX_STAINS + 1);
   localparam int XW = gnto_pkg::COORD_W;
   localparam int SW = gnto_pkg::SCORE_W;
   localparam int DW = gnto_pkg::DIST_W;
   localparam int EW = gnto_pkg::ENTRY_W;

   gnto_pkg::state_type state_ff, state_in;

   logic [CW-1:0]         count_ff, count_in;
   logic                  drop_ff, drop_in;
   logic [MAX_STAINS-1:0] visited_ff, visited_in;
   logic [CW-1:0]         issue_ff, issue_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         pend_idx_ff, pend_idx_in;
   logic                  found_ff, found_in;
   logic [CW-1:0]         pick_ff, pick_in;
   logic [AW-1:0]         best_idx_ff, best_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic signed [XW-1:0] start_x_ff, start_y_ff;
   logic signed [XW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [XW-1:0] best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic [SW-1:0]        best_score_ff, best_score_in;
   logic [DW-1:0]        best_d_ff, best_d_in;

   logic signed [XW-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [SW-1:0]        rsp_score_ff, rsp_score_in;
   logic [DW-1:0]        rsp_dist_ff, rsp_dist_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_empty_ff, rsp_empty_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   logic          ram_we;
   logic [AW-1:0] ram_raddr;
   logic [EW-1:0] ram_rdata;

   logic signed [XW-1:0] rd_x, rd_y;
   logic [SW-1:0]        rd_score;
   logic signed [XW:0]   dx, dy;
   logic [XW-1:0]        adx, ady;
   logic [DW-1:0]        man_dist;
   logic                 store_full;
   logic                 last_pick;

   gnto_ram #(
      .WIDTH(EW),
      .DEPTH(MAX_STAINS)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(count_ff[AW-1:0]),
      .wdata({req_point_x, req_point_y, req_point_score}),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // Shared distance unit: Manhattan distance from the current position.
   assign rd_x     = ram_rdata[EW-1 -: XW];
   assign rd_y     = ram_rdata[EW-XW-1 -: XW];
   assign rd_score = ram_rdata[SW-1:0];
   assign dx   = {cx_ff[XW-1], cx_ff} - {rd_x[XW-1], rd_x};
   assign dy   = {cy_ff[XW-1], cy_ff} - {rd_y[XW-1], rd_y};
   assign adx  = dx[XW] ? XW'(-dx) : dx[XW-1:0];
   assign ady  = dy[XW] ? XW'(-dy) : dy[XW-1:0];
   assign man_dist = {1'b0, adx} + {1'b0, ady};

   assign store_full = (count_ff == CW'(MAX_STAINS));
   assign last_pick  = (pick_ff == (count_ff - CW'(1)));
   assign ram_raddr  = issue_ff[AW-1:0];
   assign ram_we     = (state_ff == gnto_pkg::ST_IDLE) && start &&
                       (req_cmd == gnto_pkg::CMD_LOAD) && !store_full;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      drop_in       = drop_ff;
      visited_in    = visited_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      best_idx_in   = best_idx_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      best_x_in     = best_x_ff;
      best_y_in     = best_y_ff;
      best_score_in = best_score_ff;
      best_d_in     = best_d_ff;
      rsp_valid_in  = 1'b0;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_score_in  = rsp_score_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      unique case (state_ff)
         gnto_pkg::ST_IDLE: begin
            if (start) begin
               if (req_cmd == gnto_pkg::CMD_LOAD) begin
                  if (store_full) begin
                     drop_in = 1'b1;
                  end else begin
                     count_in = count_ff + CW'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = '0;
                  rsp_y_in     = '0;
                  rsp_score_in = '0;
                  rsp_dist_in  = '0;
                  rsp_last_in  = 1'b1;
                  rsp_empty_in = 1'b1;
                  rsp_ovf_in   = drop_ff;
                  drop_in      = 1'b0;
                  visited_in   = '0;
               end else begin
                  cx_in      = start_x_ff;
                  cy_in      = start_y_ff;
                  visited_in = '0;
                  issue_in   = '0;
                  found_in   = 1'b0;
                  pick_in    = '0;
                  state_in   = gnto_pkg::ST_SCAN;
               end
            end
         end
         gnto_pkg::ST_SCAN: begin
            if (issue_ff != count_ff) begin
               issue_in    = issue_ff + CW'(1);
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[AW-1:0];
            end
            // Strict less-than keeps the lowest index on a tie.
            if (pend_ff && !visited_ff[pend_idx_ff] &&
                (!found_ff || man_dist < best_d_ff)) begin
               found_in      = 1'b1;
               best_idx_in   = pend_idx_ff;
               best_x_in     = rd_x;
               best_y_in     = rd_y;
               best_score_in = rd_score;
               best_d_in     = man_dist;
            end
            if (issue_ff == count_ff && !pend_ff) begin
               state_in = gnto_pkg::ST_EMIT;
            end
         end
         gnto_pkg::ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_x_in     = best_x_ff;
            rsp_y_in     = best_y_ff;
            rsp_score_in = best_score_ff;
            rsp_dist_in  = best_d_ff;
            rsp_last_in  = last_pick;
            rsp_empty_in = 1'b0;
            rsp_ovf_in   = drop_ff;
            visited_in[best_idx_ff] = 1'b1;
            cx_in    = best_x_ff;
            cy_in    = best_y_ff;
            issue_in = '0;
            found_in = 1'b0;
            pick_in  = pick_ff + CW'(1);
            if (last_pick) begin
               count_in   = '0;
               drop_in    = 1'b0;
               visited_in = '0;
               state_in   = gnto_pkg::ST_IDLE;
            end else begin
               state_in = gnto_pkg::ST_SCAN;
            end
         end
         default: begin
            state_in = gnto_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gnto_pkg::ST_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         visited_ff   <= '0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         pick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         visited_ff   <= visited_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         pick_ff      <= pick_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == gnto_pkg::CSR_START_X) begin
            start_x_ff <= csr_wdata;
         end
         if (csr_we && csr_index == gnto_pkg::CSR_START_Y) begin
            start_y_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff   <= pend_idx_in;
      best_idx_ff   <= best_idx_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      best_x_ff     <= best_x_in;
      best_y_ff     <= best_y_in;
      best_score_ff <= best_score_in;
      best_d_ff     <= best_d_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign busy              = (state_ff != gnto_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_x         = rsp_x_ff;
   assign rsp_out_y         = rsp_y_ff;
   assign rsp_out_score     = rsp_score_ff;
   assign rsp_step_distance = rsp_dist_ff;
   assign rsp_is_last       = rsp_last_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_overflowed    = rsp_ovf_ff;

   // Every emit must follow a scan that found an unvisited point.
   a_emit_has_pick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gnto_pkg::ST_EMIT) |-> found_ff)
      else $error("emit without a picked point");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_STAINS))
      else $error("point count beyond store depth");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |-> rsp_is_last)
      else $error("empty result not marked last");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !pend_ff)
      else $error("read in flight while idle");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_last) |-> (count_ff == '0 && !drop_ff))
      else $error("store not cleared after final result");

endmodule
`default_nettype wire

/* sim/tb_greedy_nearest_target_order_top.sv */
// Self-checking testbench for the greedy nearest target order block.
module tb_greedy_nearest_target_order_top;

   localparam int MAX_STAINS = gnto_pkg::MAX_STAINS;
   localparam int COORD_W = gnto_pkg::COORD_W;
   localparam int SCORE_W = gnto_pkg::SCORE_W;
   localparam int DIST_W = gnto_pkg::DIST_W;
   localparam int CSR_IDX_W = gnto_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = gnto_pkg::CSR_DATA_W;

   localparam int CLK_PERIOD = 10;
   localparam int RESET_CYCLES = 9;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES = 2 * MAX_STAINS;
   localparam int TIMEOUT_CYCLES = 300000;

   // Indexes beyond the start registers, which the block must ignore.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef enum int {
      MODE_WIDE,
      MODE_NEAR_ORIGIN,
      MODE_EXTREME,
      MODE_CLUSTER
   } coord_mode_type;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic        [SCORE_W-1:0] score;
      logic        [DIST_W-1:0]  distance;
      logic                      last;
      logic                      empty;
      logic                      ovf;
   } visit_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_cmd = gnto_pkg::CMD_LOAD;
   logic signed [COORD_W-1:0] req_point_x = '0;
   logic signed [COORD_W-1:0] req_point_y = '0;
   logic        [SCORE_W-1:0] req_point_score = '0;
   logic                      rsp_valid;
   logic signed [COORD_W-1:0] rsp_out_x;
   logic signed [COORD_W-1:0] rsp_out_y;
   logic        [SCORE_W-1:0] rsp_out_score;
   logic        [DIST_W-1:0]  rsp_step_distance;
   logic                      rsp_is_last;
   logic                      rsp_is_empty;
   logic                      rsp_overflowed;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = gnto_pkg::CSR_START_X;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   // Predictor state: the point store, its fill level, the overflow flag and the start cell.
   logic signed [COORD_W-1:0] stored_x [MAX_STAINS];
   logic signed [COORD_W-1:0] stored_y [MAX_STAINS];
   logic        [SCORE_W-1:0] stored_score [MAX_STAINS];
   int                        stored_count = 0;
   bit                        drop_pending = 1'b0;
   logic signed [COORD_W-1:0] tour_start_x = '0;
   logic signed [COORD_W-1:0] tour_start_y = '0;

   visit_type expected_visits[$];

   int sender_idle_pct = 0;
   int error_count = 0;
   int loads_sent = 0;
   int plans_sent = 0;
   int empty_plans = 0;
   int overflow_plans = 0;
   int csr_writes = 0;
   int visits_checked = 0;

   greedy_nearest_target_order_top dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_point_score   (req_point_score),
      .rsp_valid         (rsp_valid),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_score     (rsp_out_score),
      .rsp_step_distance (rsp_step_distance),
      .rsp_is_last       (rsp_is_last),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_overflowed    (rsp_overflowed),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   task automatic predict_load(input logic signed [COORD_W-1:0] px,
                               input logic signed [COORD_W-1:0] py,
                               input logic [SCORE_W-1:0] ps);
      if (stored_count < MAX_STAINS) begin
         stored_x[stored_count] = px;
         stored_y[stored_count] = py;
         stored_score[stored_count] = ps;
         stored_count++;
      end else begin
         drop_pending = 1'b1;
      end
   endtask

   // Greedy tour: from the current cell, take the nearest unused point; on equal
   // distance the earlier store entry wins because only a strictly smaller one replaces it.
   task automatic predict_route();
      int n, cx, cy, best, best_d, d, px, py;
      bit [MAX_STAINS-1:0] taken;
      visit_type v;
      n = stored_count;
      taken = '0;
      if (drop_pending) overflow_plans++;
      if (n == 0) begin
         v.x = '0;
         v.y = '0;
         v.score = '0;
         v.distance = '0;
         v.last = 1'b1;
         v.empty = 1'b1;
         v.ovf = drop_pending;
         expected_visits.insert(expected_visits.size(), v);
         empty_plans++;
      end else begin
         cx = tour_start_x;
         cy = tour_start_y;
         for (int k = 0; k < n; k++) begin
            best = -1;
            best_d = 0;
            for (int i = 0; i < n; i++) begin
               if (!taken[i]) begin
                  px = stored_x[i];
                  py = stored_y[i];
                  d = ((cx > px) ? cx - px : px - cx) + ((cy > py) ? cy - py : py - cy);
                  if (best < 0 || d < best_d) begin
                     best = i;
                     best_d = d;
                  end
               end
            end
            taken[best] = 1'b1;
            v.x = stored_x[best];
            v.y = stored_y[best];
            v.score = stored_score[best];
            v.distance = best_d[DIST_W-1:0];
            v.last = (k == n - 1);
            v.empty = 1'b0;
            v.ovf = drop_pending;
            expected_visits.insert(expected_visits.size(), v);
            cx = stored_x[best];
            cy = stored_y[best];
         end
      end
      stored_count = 0;
      drop_pending = 1'b0;
   endtask

   // Entered and left at a falling edge. Start is left high so that the next
   // transaction can follow without a gap; anything that waits lowers it first.
   task automatic send_item(input logic cmd,
                            input logic signed [COORD_W-1:0] px,
                            input logic signed [COORD_W-1:0] py,
                            input logic [SCORE_W-1:0] ps);
      if ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         do begin
            req_cmd = 1'($urandom);
            req_point_x = COORD_W'($urandom);
            req_point_y = COORD_W'($urandom);
            req_point_score = SCORE_W'($urandom);
            @(negedge clock);
         end while ($urandom_range(99) < sender_idle_pct);
      end
      start = 1'b1;
      req_cmd = cmd;
      req_point_x = px;
      req_point_y = py;
      req_point_score = ps;
      do @(posedge clock); while (busy);
      if (cmd == gnto_pkg::CMD_LOAD) begin
         predict_load(px, py, ps);
         loads_sent++;
      end else begin
         predict_route();
         plans_sent++;
      end
      @(negedge clock);
   endtask

   // A load gives no result, so after the last visit the task also waits until busy is low.
   task automatic wait_idle();
      start = 1'b0;
      while (expected_visits.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      if (idx == gnto_pkg::CSR_START_X) tour_start_x = val;
      else if (idx == gnto_pkg::CSR_START_Y) tour_start_y = val;
      csr_writes++;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_start();
      logic [CSR_DATA_W-1:0] val;
      val = CSR_DATA_W'($urandom);
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(3))
            0: val = 16'h8000;
            1: val = 16'h7FFF;
            2: val = 16'h0000;
            default: val = 16'hFFFF;
         endcase
      end
      return val;
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord(input coord_mode_type mode,
                                                           input logic signed [COORD_W-1:0] base);
      logic signed [COORD_W-1:0] val;
      int offset;
      case (mode)
         MODE_NEAR_ORIGIN: begin
            offset = int'($urandom_range(6)) - 3;
            val = offset[COORD_W-1:0];
         end
         MODE_EXTREME: begin
            case ($urandom_range(3))
               0: val = 16'sh8000;
               1: val = 16'sh7FFF;
               2: val = 16'sh0000;
               default: val = -16'sd1;
            endcase
         end
         MODE_CLUSTER: begin
            offset = int'($urandom_range(8)) - 4;
            val = base + offset[COORD_W-1:0];
         end
         default: val = COORD_W'($urandom);
      endcase
      return val;
   endfunction

   function automatic void check_field(input string name,
                                       input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      visit_type v;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_visits.size() == 0) begin
            $error("result transaction with no visit outstanding");
            error_count++;
         end else begin
            v = expected_visits.pop_front();
            check_field("out_x", v.x, rsp_out_x);
            check_field("out_y", v.y, rsp_out_y);
            check_field("out_score", v.score, rsp_out_score);
            check_field("step_distance", v.distance, rsp_step_distance);
            check_field("is_last", v.last, rsp_is_last);
            check_field("is_empty", v.empty, rsp_is_empty);
            check_field("overflowed", v.ovf, rsp_overflowed);
            visits_checked++;
         end
      end
   end

   task automatic test_empty_plan_after_reset();
      send_item(gnto_pkg::CMD_PLAN, '0, '0, '0);
      wait_idle();
   endtask

   task automatic test_single_point();
      send_item(gnto_pkg::CMD_LOAD, 16'sd3, -16'sd4, 16'hFFFF);
      send_item(gnto_pkg::CMD_PLAN, '0, '0, '0);
      wait_idle();
   endtask

   // Four points at equal distance from the origin plus a duplicate of the first.
   task automatic test_tie_break();
      send_item(gnto_pkg::CMD_LOAD, 16'sd1, 16'sd0, 16'h0001);
      send_item(gnto_pkg::CMD_LOAD, 16'sd0, 16'sd1, 16'h0002);
      send_item(gnto_pkg::CMD_LOAD, -16'sd1, 16'sd0, 16'h0003);
      send_item(gnto_pkg::CMD_LOAD, 16'sd0, -16'sd1, 16'h0004);
      send_item(gnto_pkg::CMD_LOAD, 16'sd1, 16'sd0, 16'h0005);
      send_item(gnto_pkg::CMD_PLAN, '0, '0, '0);
      wait_idle();
   endtask

   // Opposite corners of the grid give the largest possible step.
   task automatic test_coordinate_extremes();
      write_csr(gnto_pkg::CSR_START_X, 16'h8000);
      write_csr(gnto_pkg::CSR_START_Y, 16'h8000);
      send_item(gnto_pkg::CMD_LOAD, 16'sh7FFF, 16'sh7FFF, 16'h0000);
      send_item(gnto_pkg::CMD_LOAD, 16'sh8000, 16'sh8000, 16'h8000);
      send_item(gnto_pkg::CMD_PLAN, '0, '0, '0);
      wait_idle();
      write_csr(gnto_pkg::CSR_START_X, 16'h7FFF);
      write_csr(gnto_pkg::CSR_START_Y, 16'h8000);
      send_item(gnto_pkg::CMD_LOAD, 16'sh8000, 16'sh7FFF, 16'h0001);
      send_item(gnto_pkg::CMD_PLAN, '0, '0, '0);
      wait_idle();
   endtask

   task automatic test_spare_register_index();
      write_csr(gnto_pkg::CSR_START_X, 16'h0000);
      write_csr(gnto_pkg::CSR_START_Y, 16'h0000);
      write_csr(CSR_SPARE_LO, 16'hFFFF);
      write_csr(CSR_SPARE_HI, 16'h5A5A);
      send_item(gnto_pkg::CMD_LOAD, 16'sd2, 16'sd2, 16'h1234);
      send_item(gnto_pkg::CMD_PLAN, '0, '0, '0);
      wait_idle();
   endtask

   // A plan straight after a plan must find the store already cleared.
   task automatic test_back_to_back_plans();
      send_item(gnto_pkg::CMD_LOAD, -16'sd7, 16'sd9, 16'hABCD);
      send_item(gnto_pkg::CMD_PLAN, '0, '0, '0);
      send_item(gnto_pkg::CMD_PLAN, '0, '0, '0);
      wait_idle();
   endtask

   // Mostly well-formed load bursts closed by a plan; the first burst of each
   // phase overfills the store, and empty plans appear now and then.
   task automatic test_random_tours(input int idle_pct, input int budget);
      int sent, loads, roll;
      coord_mode_type mode;
      logic signed [COORD_W-1:0] base_x, base_y;
      sender_idle_pct = idle_pct;
      write_csr(gnto_pkg::CSR_START_X, pick_start());
      write_csr(gnto_pkg::CSR_START_Y, pick_start());
      sent = 0;
      while (sent < budget) begin
         roll = $urandom_range(99);
         if (sent == 0 || roll < 4) loads = MAX_STAINS + $urandom_range(1, 6);
         else if (roll < 12) loads = 0;
         else if (roll < 18) loads = $urandom_range(MAX_STAINS / 2, MAX_STAINS);
         else loads = $urandom_range(1, 8);
         mode = coord_mode_type'($urandom_range(3));
         base_x = COORD_W'($urandom);
         base_y = COORD_W'($urandom);
         for (int i = 0; i < loads; i++) begin
            send_item(gnto_pkg::CMD_LOAD, rand_coord(mode, base_x), rand_coord(mode, base_y),
                      SCORE_W'($urandom));
         end
         send_item(gnto_pkg::CMD_PLAN, COORD_W'($urandom), COORD_W'($urandom),
                   SCORE_W'($urandom));
         sent += loads + 1;
         if ($urandom_range(99) < 10) begin
            wait_idle();
            write_csr(gnto_pkg::CSR_START_X, pick_start());
            write_csr(gnto_pkg::CSR_START_Y, pick_start());
         end
      end
      wait_idle();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;
      test_empty_plan_after_reset();
      test_single_point();
      test_tie_break();
      test_coordinate_extremes();
      test_spare_register_index();
      test_back_to_back_plans();
      test_random_tours(23, 165);
      test_random_tours(61, 165);
      test_random_tours(0, 170);
      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("tb: %0d transactions sent (%0d loads, %0d plans), %0d visits checked",
               loads_sent + plans_sent, loads_sent, plans_sent, visits_checked);
      $display("tb: %0d empty plans, %0d plans after overfill, %0d register writes",
               empty_plans, overflow_plans, csr_writes);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("tb: failure");
      $finish;
   end

endmodule
